[design/h2r_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared widths, item types and codes for the hsv to rgb converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int HUE_W    = 11;
  localparam int CHAN_W   = 8;
  localparam int FRAC_W   = 8;
  localparam int SECT_W   = HUE_W - FRAC_W;
  localparam int PACK_W   = 3 * CHAN_W;
  localparam int FULL_W   = CHAN_W + FRAC_W;
  localparam int NUM_W    = 2 * CHAN_W;

  localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'((1 << CHAN_W) - 1);
  localparam logic [FRAC_W:0]   FRAC_ONE = (FRAC_W+1)'(1 << FRAC_W);
  localparam logic [FULL_W-1:0] FULL_SCALE =
    FULL_W'(((1 << CHAN_W) - 1) * (1 << FRAC_W));
  localparam logic [HUE_W-1:0]  HUE_CIRCLE = HUE_W'(6 * (1 << FRAC_W));
  localparam logic [SECT_W-1:0] SECT_COUNT = SECT_W'(6);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_COLOR,
    MODE_GRAY,
    MODE_BLACK
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [SECT_W-1:0] sector;
    logic [FRAC_W-1:0] frac;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
  } item_t;

endpackage

[design/h2r_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_in_if
// Input channel: one hsv triple per transfer.
// ----------------------------------------------------------------------------
interface h2r_in_if;
  logic                       valid;
  logic                       ready;
  logic [h2r_pkg::HUE_W-1:0]  hue;
  logic [h2r_pkg::CHAN_W-1:0] saturation;
  logic [h2r_pkg::CHAN_W-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

[design/h2r_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_out_if
// Result channel: one rgb color per transfer.
// ----------------------------------------------------------------------------
interface h2r_out_if;
  logic                       valid;
  logic                       ready;
  logic [h2r_pkg::CHAN_W-1:0] red;
  logic [h2r_pkg::CHAN_W-1:0] green;
  logic [h2r_pkg::CHAN_W-1:0] blue;
  logic [h2r_pkg::PACK_W-1:0] packed_color;

  modport source (output valid, red, green, blue, packed_color, input ready);
  modport sink   (input valid, red, green, blue, packed_color, output ready);
endinterface

[design/h2r_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_front
// Takes input transfers, wraps the hue, splits sector and fraction and
// classifies each item as gray, black or color.
// ----------------------------------------------------------------------------
module h2r_front (
  input  logic           clk,
  input  logic           rst_n,
  h2r_in_if.sink         in_ch,
  output logic           item_vld,
  output h2r_pkg::item_t item,
  input  logic           item_rdy
);
  import h2r_pkg::*;

  logic              fr_vld_r, fr_vld_nxt;
  item_t             fr_item_r;
  item_t             cls;
  logic [HUE_W-1:0]  hue_w;
  logic              take;

  always_comb begin
    hue_w      = (in_ch.hue == HUE_CIRCLE) ? '0 : in_ch.hue;
    cls.sector = hue_w[HUE_W-1:FRAC_W];
    cls.frac   = hue_w[FRAC_W-1:0];
    cls.sat    = in_ch.saturation;
    cls.bri    = in_ch.brightness;
    if (in_ch.saturation == '0) begin
      cls.mode = MODE_GRAY;
    end else if (cls.sector >= SECT_COUNT) begin
      cls.mode = MODE_BLACK;
    end else begin
      cls.mode = MODE_COLOR;
    end
  end

  assign in_ch.ready = !fr_vld_r || item_rdy;
  assign take        = in_ch.valid && in_ch.ready;
  assign fr_vld_nxt  = take ? 1'b1 : (item_rdy ? 1'b0 : fr_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= cls;
    end
  end

  assign item_vld = fr_vld_r;
  assign item     = fr_item_r;

endmodule

[design/h2r_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module h2r_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_vld,
  input  h2r_pkg::item_t push_item,
  output logic           push_rdy,
  output logic           pop_vld,
  output h2r_pkg::item_t pop_item,
  input  logic           pop_rdy
);
  import h2r_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_rdy = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign push     = push_vld && push_rdy;
  assign pop      = pop_vld && pop_rdy;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/h2r_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_back
// Arithmetic pipeline: saturation terms, brightness products, divide by the
// channel maximum through an estimate and one correction, sector mapping.
// ----------------------------------------------------------------------------
module h2r_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_vld,
  input  h2r_pkg::item_t item,
  output logic           item_rdy,
  h2r_out_if.source      out_ch
);
  import h2r_pkg::*;

  // stage 1: saturation terms
  logic              s1_vld_r;
  mode_t             s1_mode_r;
  logic [SECT_W-1:0] s1_sect_r;
  logic [CHAN_W-1:0] s1_bri_r;
  logic [CHAN_W-1:0] s1_msat_r;
  logic [FULL_W-1:0] s1_sf_r;
  logic [FULL_W-1:0] s1_sfc_r;
  // stage 2: brightness products, q and t already shifted down by FRAC_W bits
  logic              s2_vld_r;
  mode_t             s2_mode_r;
  logic [SECT_W-1:0] s2_sect_r;
  logic [CHAN_W-1:0] s2_bri_r;
  logic [NUM_W-1:0]  s2_np_r, s2_nq_r, s2_nt_r;
  // stage 3: quotient estimates
  logic              s3_vld_r;
  mode_t             s3_mode_r;
  logic [SECT_W-1:0] s3_sect_r;
  logic [CHAN_W-1:0] s3_bri_r;
  logic [NUM_W-1:0]  s3_xp_r, s3_xq_r, s3_xt_r;
  logic [CHAN_W-1:0] s3_ep_r, s3_eq_r, s3_et_r;
  // output register
  logic              out_vld_r;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;

  logic              rdy_out, rdy3, rdy2, rdy1;
  logic [FULL_W:0]   sfc_full;
  logic [CHAN_W+FULL_W-1:0] prod_q, prod_t;
  logic [NUM_W-1:0]  prod_p;
  logic [CHAN_W-1:0] ep, eq, et;
  logic [CHAN_W-1:0] p_val, q_val, t_val;
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt;

  // floor(x / CHAN_MAX) is est or est + 1
  function automatic logic [CHAN_W-1:0] div_est(input logic [NUM_W-1:0] x);
    logic [NUM_W:0] sum;
    sum = {1'b0, x} + (NUM_W+1)'(x >> CHAN_W);
    return sum[NUM_W-1:CHAN_W];
  endfunction

  function automatic logic [CHAN_W-1:0] div_fix(input logic [NUM_W-1:0] x,
                                                input logic [CHAN_W-1:0] e);
    logic [NUM_W-1:0] rem;
    rem = x - {e, {CHAN_W{1'b0}}} + NUM_W'(e);
    return (rem >= NUM_W'(CHAN_MAX)) ? e + 1'b1 : e;
  endfunction

  assign rdy_out  = !out_vld_r || out_ch.ready;
  assign rdy3     = !s3_vld_r || rdy_out;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;
  assign item_rdy = rdy1;

  assign sfc_full = (FULL_W+1)'(item.sat) * (FULL_W+1)'(FRAC_ONE - {1'b0, item.frac});
  assign prod_p   = NUM_W'(s1_bri_r) * NUM_W'(s1_msat_r);
  assign prod_q   = (CHAN_W+FULL_W)'(s1_bri_r) * (CHAN_W+FULL_W)'(FULL_SCALE - s1_sf_r);
  assign prod_t   = (CHAN_W+FULL_W)'(s1_bri_r) * (CHAN_W+FULL_W)'(FULL_SCALE - s1_sfc_r);

  assign ep = div_est(s2_np_r);
  assign eq = div_est(s2_nq_r);
  assign et = div_est(s2_nt_r);

  assign p_val = div_fix(s3_xp_r, s3_ep_r);
  assign q_val = div_fix(s3_xq_r, s3_eq_r);
  assign t_val = div_fix(s3_xt_r, s3_et_r);

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    case (s3_mode_r)
      MODE_GRAY: begin
        red_nxt   = s3_bri_r;
        green_nxt = s3_bri_r;
        blue_nxt  = s3_bri_r;
      end
      MODE_COLOR: begin
        case (s3_sect_r)
          SECT_W'(0): begin red_nxt = s3_bri_r; green_nxt = t_val; blue_nxt = p_val; end
          SECT_W'(1): begin red_nxt = q_val; green_nxt = s3_bri_r; blue_nxt = p_val; end
          SECT_W'(2): begin red_nxt = p_val; green_nxt = s3_bri_r; blue_nxt = t_val; end
          SECT_W'(3): begin red_nxt = p_val; green_nxt = q_val; blue_nxt = s3_bri_r; end
          SECT_W'(4): begin red_nxt = t_val; green_nxt = p_val; blue_nxt = s3_bri_r; end
          SECT_W'(5): begin red_nxt = s3_bri_r; green_nxt = p_val; blue_nxt = q_val; end
          default: begin
            red_nxt   = '0;
            green_nxt = '0;
            blue_nxt  = '0;
          end
        endcase
      end
      default: begin
        red_nxt   = '0;
        green_nxt = '0;
        blue_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_vld_r <= item_vld;
      end
      if (rdy2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (rdy3) begin
        s3_vld_r <= s2_vld_r;
      end
      if (rdy_out) begin
        out_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && item_vld) begin
      s1_mode_r <= item.mode;
      s1_sect_r <= item.sector;
      s1_bri_r  <= item.bri;
      s1_msat_r <= CHAN_MAX - item.sat;
      s1_sf_r   <= FULL_W'(item.sat) * FULL_W'(item.frac);
      s1_sfc_r  <= sfc_full[FULL_W-1:0];
    end
    if (rdy2 && s1_vld_r) begin
      s2_mode_r <= s1_mode_r;
      s2_sect_r <= s1_sect_r;
      s2_bri_r  <= s1_bri_r;
      s2_np_r   <= prod_p;
      // dividing by chan_max * 2^frac is a shift then a divide by chan_max
      s2_nq_r   <= prod_q[CHAN_W+FULL_W-1:FRAC_W];
      s2_nt_r   <= prod_t[CHAN_W+FULL_W-1:FRAC_W];
    end
    if (rdy3 && s2_vld_r) begin
      s3_mode_r <= s2_mode_r;
      s3_sect_r <= s2_sect_r;
      s3_bri_r  <= s2_bri_r;
      s3_xp_r   <= s2_np_r;
      s3_xq_r   <= s2_nq_r;
      s3_xt_r   <= s2_nt_r;
      s3_ep_r   <= ep;
      s3_eq_r   <= eq;
      s3_et_r   <= et;
    end
    if (rdy_out && s3_vld_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.red          = red_r;
  assign out_ch.green        = green_r;
  assign out_ch.blue         = blue_r;
  assign out_ch.packed_color = {red_r, green_r, blue_r};

endmodule

[design/hsv_to_rgb_converter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Fixed-point hsv to rgb color conversion, one pixel per clock.
//
//   channel  direction  fields
//   in_ch    input      hue[10:0], saturation[7:0], brightness[7:0]
//   out_ch   output     red[7:0], green[7:0], blue[7:0], packed_color[23:0]
//
// One transfer per clock in and out when neither side stalls.
// A pixel passes through the front register, the queue, three arithmetic
// stages and the output register.
// Synchronous active-low reset clears all valid and pointer state.
// A stalled output backs up the pipeline, then the queue, then in_ch.ready.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
  input logic        clk,
  input logic        rst_n,
  h2r_in_if.sink     in_ch,
  h2r_out_if.source  out_ch
);
  import h2r_pkg::*;

  logic  fr_vld, fr_rdy;
  item_t fr_item;
  logic  q_vld, q_rdy;
  item_t q_item;

  h2r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .item_vld (fr_vld),
    .item     (fr_item),
    .item_rdy (fr_rdy)
  );

  h2r_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (fr_vld),
    .push_item (fr_item),
    .push_rdy  (fr_rdy),
    .pop_vld   (q_vld),
    .pop_item  (q_item),
    .pop_rdy   (q_rdy)
  );

  h2r_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (q_vld),
    .item     (q_item),
    .item_rdy (q_rdy),
    .out_ch   (out_ch)
  );

  // packed word always mirrors the channels
  a_packed_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.packed_color == {out_ch.red, out_ch.green, out_ch.blue})
    else $error("packed_color does not match channels");

  // black only for hue past the full circle
  a_black_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_vld && fr_item.mode == MODE_BLACK) |-> fr_item.sector >= SECT_COUNT)
    else $error("black item in a valid sector");

  // gray only for zero saturation
  a_gray_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_vld && fr_item.mode == MODE_GRAY) |-> fr_item.sat == '0)
    else $error("gray item with nonzero saturation");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the hsv to rgb converter on its two streaming channels. A short list
// of directed pixels covers the corner colors, gray, the 360 degree wrap and
// hue codes past the full circle. About 1700 random pixels follow. Every pixel
// is run through a local fixed-point predictor. Each color that comes out is
// compared field by field with the oldest pending prediction. The sender works
// in bursts with gaps between them, and the receiver stalls in shifting
// patterns.
// ----------------------------------------------------------------------------
module testbench;
  import h2r_pkg::*;

  localparam int NUM_DIRECTED   = 22;
  localparam int NUM_RANDOM     = 1700;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [PACK_W-1:0] packed_color;
  } color_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
    bit                has_known;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_row_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC,
    RX_LONG
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  h2r_in_if  in_ch ();
  h2r_out_if out_ch ();

  hsv_to_rgb_converter_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  color_t      pending_colors[$];
  color_t      front_color;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned gray_count     = 0;
  int unsigned black_count    = 0;
  int unsigned wrap_count     = 0;
  int unsigned color_count    = 0;
  int unsigned burst_left     = 0;
  int unsigned idle_cycles    = 0;

  // hue in sectors of 2^FRAC_W steps, sat and bri scaled to CHAN_MAX
  function automatic color_t hsv_to_rgb(logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat,
                                        logic [CHAN_W-1:0] bri);
    int unsigned h, s, v, m, one, full, sector, frac, p, q, t, r, g, b;
    color_t c;
    h    = 32'(hue);
    s    = 32'(sat);
    v    = 32'(bri);
    m    = 32'(CHAN_MAX);
    one  = 1 << FRAC_W;
    full = m * one;
    if (s == 0) begin
      r = v;
      g = v;
      b = v;
    end else begin
      if (h == 32'(HUE_CIRCLE)) h = 0;
      sector = h >> FRAC_W;
      frac   = h & (one - 1);
      p = v * (m - s) / m;
      q = v * (full - s * frac) / full;
      t = v * (full - s * (one - frac)) / full;
      case (sector)
        0: begin r = v; g = t; b = p; end
        1: begin r = q; g = v; b = p; end
        2: begin r = p; g = v; b = t; end
        3: begin r = p; g = q; b = v; end
        4: begin r = t; g = p; b = v; end
        5: begin r = v; g = p; b = q; end
        default: begin r = 0; g = 0; b = 0; end
      endcase
    end
    c.red          = r[CHAN_W-1:0];
    c.green        = g[CHAN_W-1:0];
    c.blue         = b[CHAN_W-1:0];
    c.packed_color = {c.red, c.green, c.blue};
    return c;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // bursts of random length, gaps filled with junk on the payload
  task automatic sender_pause();
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid      <= 1'b0;
        in_ch.hue        <= HUE_W'($urandom);
        in_ch.saturation <= CHAN_W'($urandom);
        in_ch.brightness <= CHAN_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CHAN_W-1:0] sat,
                            input logic [CHAN_W-1:0] bri, input bit has_known,
                            input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
    color_t want;
    want = hsv_to_rgb(hue, sat, bri);
    if (has_known) begin
      want.red          = r;
      want.green        = g;
      want.blue         = b;
      want.packed_color = {r, g, b};
    end
    if (sat == 0) gray_count++;
    else if (hue > HUE_CIRCLE) black_count++;
    else begin
      color_count++;
      if (hue == HUE_CIRCLE) wrap_count++;
    end
    sender_pause();
    in_ch.valid      <= 1'b1;
    in_ch.hue        <= hue;
    in_ch.saturation <= sat;
    in_ch.brightness <= bri;
    do @(posedge clk); while (!in_ch.ready);
    pending_colors.push_back(want);
  endtask

  task automatic send_random_pixel();
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) hue = HUE_W'($urandom_range(0, HUE_CIRCLE - 1));
    else if (pick < 75) hue = HUE_CIRCLE;
    else if (pick < 85) hue = HUE_W'($urandom_range(HUE_CIRCLE + 1, (1 << HUE_W) - 1));
    else begin
      // land on or next to a sector boundary
      hue = HUE_W'($urandom_range(0, 5) * (1 << FRAC_W));
      case ($urandom_range(0, 2))
        0: hue = hue + HUE_W'(1);
        1: hue = hue + HUE_W'((1 << FRAC_W) - 1);
        default: ;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) sat = '0;
    else if (pick < 20) sat = CHAN_MAX;
    else if (pick < 25) sat = CHAN_W'(1);
    else sat = CHAN_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) bri = '0;
    else if (pick < 20) bri = CHAN_MAX;
    else bri = CHAN_W'($urandom);
    send_pixel(hue, sat, bri, 1'b0, '0, '0, '0);
  endtask

  // the receiver moves between randomly chosen stall patterns
  initial begin : receiver
    stall_mode_t stall_mode;
    int unsigned cyc;
    stall_mode   = RX_OPEN;
    cyc          = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 150 == 0) stall_mode = stall_mode_t'($urandom_range(RX_OPEN, RX_LONG));
      case (stall_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_LIGHT:    out_ch.ready <= ($urandom_range(0, 9) >= 3);
        RX_HEAVY:    out_ch.ready <= ($urandom_range(0, 9) >= 8);
        RX_PERIODIC: out_ch.ready <= ((cyc % 7) >= 3);
        default:     out_ch.ready <= ((cyc % 32) >= 24);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_colors.size() == 0) begin
        $error("color transfer with nothing pending: 0x%06h", out_ch.packed_color);
        mismatch_count++;
      end else begin
        front_color = pending_colors.pop_front();
        check_field("red", 32'(front_color.red), 32'(out_ch.red));
        check_field("green", 32'(front_color.green), 32'(out_ch.green));
        check_field("blue", 32'(front_color.blue), 32'(out_ch.blue));
        check_field("packed_color", 32'(front_color.packed_color),
                    32'(out_ch.packed_color));
        results_seen++;
      end
    end
  end

  // no transfer on either channel for too long means the block hung
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    pixel_row_t directed_rows [NUM_DIRECTED];
    directed_rows = '{
      // gray: color ignored when saturation is zero
      '{11'd0,    8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
      '{11'd0,    8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
      '{11'd700,  8'd0,   8'd100, 1'b1, 8'd100, 8'd100, 8'd100},
      '{11'd2047, 8'd0,   8'd77,  1'b1, 8'd77,  8'd77,  8'd77},
      // primaries and secondaries at full scale
      '{11'd0,    8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
      '{11'd256,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
      '{11'd512,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
      '{11'd768,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
      '{11'd1024, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
      '{11'd1280, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
      // 360 degrees wraps to red
      '{11'd1536, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
      // past the full circle with color, and zero brightness: black
      '{11'd1537, 8'd1,   8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
      '{11'd1792, 8'd128, 8'd200, 1'b1, 8'd0,   8'd0,   8'd0},
      '{11'd2047, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
      '{11'd300,  8'd200, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
      // fractions at the sector edges and mid values
      '{11'd255,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
      '{11'd1535, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
      '{11'd128,  8'd128, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
      '{11'd383,  8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
      '{11'd1100, 8'd37,  8'd250, 1'b0, 8'd0,   8'd0,   8'd0},
      '{11'd900,  8'd254, 8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
      '{11'd1535, 8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0}
    };
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.hue        = '0;
    in_ch.saturation = '0;
    in_ch.brightness = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].bri,
                 directed_rows[i].has_known, directed_rows[i].red,
                 directed_rows[i].green, directed_rows[i].blue);
    end
    repeat (NUM_RANDOM) send_random_pixel();

    in_ch.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels sent, %0d colors checked: %0d gray, %0d black past the circle,",
             gray_count + black_count + color_count, results_seen, gray_count, black_count);
    $display("%0d colored (%0d at the 360 degree wrap), %0d mismatches",
             color_count, wrap_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
